// ----- design/qmn_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion multiply-normalize package
// Shared widths and the stage-to-stage record types of the pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

	localparam int CompW   = 16;   // Q2.14 component
	localparam int RawW    = 35;   // signed raw product component
	localparam int MagW    = 34;   // magnitude of raw component
	localparam int MantW   = 24;   // normalized mantissa, leading one at bit 23
	localparam int MantTop = 23;
	localparam int SumW    = 50;   // sum of four mantissa squares
	localparam int RootW   = 25;   // square root of the sum
	localparam int SqrtSteps = 25; // one result bit per stage
	localparam int QuoW    = 15;   // quotient magnitude, at most 16384
	localparam int DivSteps = 15;  // one quotient bit per stage
	localparam int NumW    = MantW + 16; // n*2^15 + r
	localparam int LeadW   = 6;

	typedef logic signed [CompW-1:0] comp_t;
	typedef logic [MantW-1:0] mant_t;

	// Item state while the square root is formed.
	typedef struct packed {
		logic            zero;
		logic [3:0]      neg;
		mant_t [3:0]     n;
		logic [SumW-1:0] rem;
		logic [RootW-1:0] res;
	} sqrt_rec_t;

	// Item state while the four quotients are formed.
	typedef struct packed {
		logic                 zero;
		logic [3:0]           neg;
		logic [RootW:0]       den;
		logic [3:0][NumW-1:0] num;
		logic [3:0][QuoW-1:0] quo;
	} div_rec_t;

	// Index of the leading one of a 34-bit value (0 for zero).
	function automatic logic [LeadW-1:0] lead_one(input logic [MagW-1:0] v);
		logic [LeadW-1:0] l;
		l = '0;
		for (int i = 0; i < MagW; i++) begin
			if (v[i]) begin
				l = LeadW'(i);
			end
		end
		return l;
	endfunction

endpackage

// ----- design/qmn_product.sv -----
// ----------------------------------------------------------------------------
// Quaternion product stages
// Sixteen registered products, then summed into the four raw components.
// ----------------------------------------------------------------------------
module qmn_product import qmn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vin,
	input  logic [8*CompW-1:0]    din,
	output logic                  vout,
	output logic signed [RawW-1:0] raw [4]
);

	comp_t ax, ay, az, aw, bx, by, bz, bw;
	logic signed [31:0] m_s1 [16];
	logic               v_s1;

	assign ax = din[0*CompW +: CompW];
	assign ay = din[1*CompW +: CompW];
	assign az = din[2*CompW +: CompW];
	assign aw = din[3*CompW +: CompW];
	assign bx = din[4*CompW +: CompW];
	assign by = din[5*CompW +: CompW];
	assign bz = din[6*CompW +: CompW];
	assign bw = din[7*CompW +: CompW];

	// Stage 1: partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0]  <= ax * bw;  m_s1[1]  <= bx * aw;
			m_s1[2]  <= ay * bz;  m_s1[3]  <= az * by;
			m_s1[4]  <= ay * bw;  m_s1[5]  <= by * aw;
			m_s1[6]  <= az * bx;  m_s1[7]  <= ax * bz;
			m_s1[8]  <= az * bw;  m_s1[9]  <= bz * aw;
			m_s1[10] <= ax * by;  m_s1[11] <= ay * bx;
			m_s1[12] <= aw * bw;  m_s1[13] <= ax * bx;
			m_s1[14] <= ay * by;  m_s1[15] <= az * bz;
		end
	end

	// Stage 2: four-term sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw[0] <= RawW'(m_s1[0]) + RawW'(m_s1[1]) + RawW'(m_s1[2]) - RawW'(m_s1[3]);
			raw[1] <= RawW'(m_s1[4]) + RawW'(m_s1[5]) + RawW'(m_s1[6]) - RawW'(m_s1[7]);
			raw[2] <= RawW'(m_s1[8]) + RawW'(m_s1[9]) + RawW'(m_s1[10]) - RawW'(m_s1[11]);
			raw[3] <= RawW'(m_s1[12]) - RawW'(m_s1[13]) - RawW'(m_s1[14]) - RawW'(m_s1[15]);
		end
	end

endmodule

// ----- design/qmn_scale.sv -----
// ----------------------------------------------------------------------------
// Block-floating scale stages
// Magnitudes, common shift to put the largest leading one at bit 23, squares.
// ----------------------------------------------------------------------------
module qmn_scale import qmn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vin,
	input  logic signed [RawW-1:0] raw [4],
	output logic                   vout,
	output sqrt_rec_t              rec
);

	logic [MagW-1:0]  mag_s3 [4];
	logic [3:0]       neg_s3;
	logic             v_s3;
	mant_t            n_s4 [4];
	logic [3:0]       neg_s4;
	logic             zero_s4;
	logic             v_s4;
	logic [47:0]      sq_s5 [4];
	mant_t            n_s5 [4];
	logic [3:0]       neg_s5;
	logic             zero_s5;
	logic             v_s5;
	logic [LeadW-1:0] lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0; vout <= 1'b0;
		end else if (en) begin
			v_s3 <= vin; v_s4 <= v_s3; v_s5 <= v_s4; vout <= v_s5;
		end
	end

	// Stage 3: magnitudes and signs.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s3[i] <= raw[i][RawW-1] ? MagW'(-raw[i]) : MagW'(raw[i]);
				neg_s3[i] <= raw[i][RawW-1];
			end
		end
	end

	// Leading one of the OR of magnitudes equals that of the largest one.
	always_comb begin
		lead = lead_one(mag_s3[0] | mag_s3[1] | mag_s3[2] | mag_s3[3]);
	end

	// Stage 4: common shift.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (lead < LeadW'(MantTop)) begin
					n_s4[i] <= MantW'(mag_s3[i] << (LeadW'(MantTop) - lead));
				end else begin
					n_s4[i] <= MantW'(mag_s3[i] >> (lead - LeadW'(MantTop)));
				end
			end
			neg_s4  <= neg_s3;
			zero_s4 <= ((mag_s3[0] | mag_s3[1] | mag_s3[2] | mag_s3[3]) == '0);
		end
	end

	// Stage 5: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s5[i] <= n_s4[i] * n_s4[i];
				n_s5[i]  <= n_s4[i];
			end
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	// Stage 6: sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			rec.rem  <= SumW'(sq_s5[0]) + SumW'(sq_s5[1]) + SumW'(sq_s5[2]) + SumW'(sq_s5[3]);
			rec.res  <= '0;
			rec.neg  <= neg_s5;
			rec.zero <= zero_s5;
			for (int i = 0; i < 4; i++) begin
				rec.n[i] <= n_s5[i];
			end
		end
	end

endmodule

// ----- design/qmn_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one result bit per stage.
// ----------------------------------------------------------------------------
module qmn_sqrt import qmn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vin,
	input  sqrt_rec_t rin,
	output logic      vout,
	output sqrt_rec_t rout
);

	sqrt_rec_t rec_q [SqrtSteps+1];
	logic      v_q   [SqrtSteps+1];

	assign rec_q[0] = rin;
	assign v_q[0]   = vin;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		localparam int Sh = 2 * (SqrtSteps - 1 - k);
		logic [SumW+1:0] trial;
		logic [SumW+1:0] rem_w;
		sqrt_rec_t       nxt;
		// Trial subtraction for one root bit.
		always_comb begin
			trial = ({(SumW+2-RootW)'(0), rec_q[k].res} << (Sh + 2))
				| ((SumW+2)'(1) << Sh);
			rem_w = {2'b00, rec_q[k].rem};
			nxt   = rec_q[k];
			if (rem_w >= trial) begin
				nxt.rem = SumW'(rem_w - trial);
				nxt.res = {rec_q[k].res[RootW-2:0], 1'b1};
			end else begin
				nxt.res = {rec_q[k].res[RootW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rec_q[k+1] <= nxt;
			end
		end
	end

	assign vout = v_q[SqrtSteps];
	assign rout = rec_q[SqrtSteps];

endmodule

// ----- design/qmn_divide.sv -----
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Four restoring quotients (n*2^15 + r) / 2r, one bit per stage.
// ----------------------------------------------------------------------------
module qmn_divide import qmn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vin,
	input  sqrt_rec_t rin,
	output logic      vout,
	output div_rec_t  rout
);

	div_rec_t rec_q [DivSteps+1];
	logic     v_q   [DivSteps+1];
	div_rec_t first;

	// Set up numerators and the doubled root.
	always_comb begin
		first.zero = rin.zero;
		first.neg  = rin.neg;
		first.den  = {rin.res, 1'b0};
		first.quo  = '0;
		for (int i = 0; i < 4; i++) begin
			first.num[i] = {rin.n[i], 16'h0000} - {rin.n[i], 16'h0000} / 2
				+ NumW'(rin.res);
		end
	end

	assign rec_q[0] = first;
	assign v_q[0]   = vin;

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		localparam int Sh = DivSteps - 1 - k;
		logic [NumW+DivSteps-1:0] dsh;
		div_rec_t                 nxt;
		assign dsh = (NumW+DivSteps)'(rec_q[k].den) << Sh;
		// Trial subtraction for one quotient bit of each component.
		always_comb begin
			nxt = rec_q[k];
			for (int i = 0; i < 4; i++) begin
				if ((NumW+DivSteps)'(rec_q[k].num[i]) >= dsh) begin
					nxt.num[i]     = NumW'((NumW+DivSteps)'(rec_q[k].num[i]) - dsh);
					nxt.quo[i][Sh] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rec_q[k+1] <= nxt;
			end
		end
	end

	assign vout = v_q[DivSteps];
	assign rout = rec_q[DivSteps];

endmodule

// ----- design/quaternion_multiply_normalize.sv -----
// ----------------------------------------------------------------------------
// Normalized quaternion multiply
// Hamilton product of two Q2.14 quaternions scaled to unit length.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// s_axis   in         s_axis_tvalid/tready    a_x a_y a_z a_w b_x b_y b_z b_w
// m_axis   out        m_axis_tvalid/tready    p_x p_y p_z p_w, tuser zero_norm
//
// One item enters per cycle while the output does not stall.
// The pipeline includes the 25-stage square root and the 15-stage divider.
// arst_n clears all valid bits; data registers are not reset.
// A stall on the output freezes the whole pipeline and refuses input,
// losing nothing.
module quaternion_multiply_normalize import qmn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // p_x, p_y, p_z, p_w
	output logic         m_axis_tuser   // zero_norm
);

	logic                   en;
	logic                   v_prod, v_scale, v_sqrt, v_div;
	logic signed [RawW-1:0] raw [4];
	sqrt_rec_t              sc_rec, sq_rec;
	div_rec_t               dv_rec;

	// The pipeline advances when the output register is empty or drained.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	qmn_product u_prod (
		.clk, .arst_n, .en, .vin(s_axis_tvalid && s_axis_tready), .din(s_axis_tdata),
		.vout(v_prod), .raw
	);

	qmn_scale u_scale (
		.clk, .arst_n, .en, .vin(v_prod), .raw, .vout(v_scale), .rec(sc_rec)
	);

	qmn_sqrt u_sqrt (
		.clk, .arst_n, .en, .vin(v_scale), .rin(sc_rec), .vout(v_sqrt), .rout(sq_rec)
	);

	qmn_divide u_div (
		.clk, .arst_n, .en, .vin(v_sqrt), .rin(sq_rec), .vout(v_div), .rout(dv_rec)
	);

	// Output register: sign applied, zero product forced to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_div;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (dv_rec.zero) begin
					m_axis_tdata[i*CompW +: CompW] <= '0;
				end else if (dv_rec.neg[i]) begin
					m_axis_tdata[i*CompW +: CompW] <= -CompW'(dv_rec.quo[i]);
				end else begin
					m_axis_tdata[i*CompW +: CompW] <= CompW'(dv_rec.quo[i]);
				end
			end
			m_axis_tuser <= dv_rec.zero;
		end
	end

`ifndef SYNTH
	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
		else $error("result changed under stall");
	// A zero-norm result carries all-zero components.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("zero-norm result not zero");
	// Input is refused only while the output stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused without output stall");
`endif

endmodule

// ----- dv/tb_quaternion_multiply_normalize.sv -----
// ----------------------------------------------------------------------------
// Normalized quaternion multiply testbench
// Drives quaternion pairs into the stream input, predicts the normalized
// Hamilton product of each item with an integer model, and compares every
// output item field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_multiply_normalize;
	import qmn_pkg::*;

	localparam int Latency = 60;
	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic              zero;
		logic [3:0][15:0]  p;
	} quat_out_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;  // p_x, p_y, p_z, p_w
	logic         m_axis_tuser;  // zero_norm

	quat_out_t expected_products[$];
	int  errors;
	int  cycles;
	bit  send_idle;
	bit  recv_idle;
	int  hold_cycles;

	quaternion_multiply_normalize uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Integer square root, bit by bit.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] one;
		res = 0;
		one = 64'd1 << 62;
		while (one > v) one = one >> 2;
		while (one != 0) begin
			if (v >= res + one) begin
				v = v - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// Predict the normalized product of one input item.
	function automatic quat_out_t normalized_product(input logic [127:0] d);
		longint c[8];
		longint raw[4];
		logic [63:0] mag[4];
		logic [63:0] peak, sum, root, quo;
		int lead;
		quat_out_t r;
		for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
		raw[0] = c[0]*c[7] + c[4]*c[3] + (c[1]*c[6] - c[2]*c[5]);
		raw[1] = c[1]*c[7] + c[5]*c[3] + (c[2]*c[4] - c[0]*c[6]);
		raw[2] = c[2]*c[7] + c[6]*c[3] + (c[0]*c[5] - c[1]*c[4]);
		raw[3] = c[3]*c[7] - (c[0]*c[4] + c[1]*c[5] + c[2]*c[6]);
		peak = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
			if (mag[i] > peak) peak = mag[i];
		end
		r = '0;
		if (peak == 0) begin
			r.zero = 1'b1;
			return r;
		end
		lead = 0;
		while ((peak >> lead) > 1) lead++;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			if (lead < MantTop) mag[i] = mag[i] << (MantTop - lead);
			else mag[i] = mag[i] >> (lead - MantTop);
			sum += mag[i] * mag[i];
		end
		root = int_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			quo = (mag[i] * 64'd32768 + root) / (2 * root);
			r.p[i] = raw[i] < 0 ? 16'(-quo) : 16'(quo);
		end
		return r;
	endfunction

	// Send one item; may idle before it when idling is enabled.
	// The valid stays high after the item so that items follow back to back.
	task automatic send_item(input logic [127:0] d);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_products.push_back(normalized_product(d));
		@(negedge clk);
	endtask

	function automatic logic [127:0] pack_pair(input logic [15:0] v[8]);
		logic [127:0] d;
		for (int i = 0; i < 8; i++) d[16*i +: 16] = v[i];
		return d;
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Stop offering items and wait until every expected result has come.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_products.size() != 0) @(negedge clk);
	endtask

	// Extremes, identity, zero product, single-bit and tiny values.
	task automatic test_directed();
		logic [15:0] v[8];
		logic [15:0] pats[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h0001};
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 8; i++) v[i] = pats[k];
			send_item(pack_pair(v));
		end
		// Identity times a quaternion, and each basis product.
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 8; i++) v[i] = 16'h0000;
			v[3] = 16'h4000;
			v[4 + k] = 16'h4000;
			send_item(pack_pair(v));
			v[3] = 16'h0000;
			v[k] = 16'hc000;
			send_item(pack_pair(v));
		end
		// Zero first quaternion gives a zero product.
		for (int i = 0; i < 8; i++) v[i] = i < 4 ? 16'h0000 : 16'h1234;
		send_item(pack_pair(v));
		// Smallest nonzero products need a large left shift.
		for (int i = 0; i < 8; i++) v[i] = 16'h0000;
		v[3] = 16'h0001; v[7] = 16'hffff;
		send_item(pack_pair(v));
		v[0] = 16'h0001; v[5] = 16'h0001;
		send_item(pack_pair(v));
		for (int i = 0; i < 8; i++) v[i] = (i % 2) ? 16'h8000 : 16'h7fff;
		send_item(pack_pair(v));
		for (int i = 0; i < 8; i++) v[i] = 16'haaaa ^ 16'(i * 16'h1111);
		send_item(pack_pair(v));
	endtask

	task automatic test_random(input int count);
		logic [15:0] v[8];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 8; i++) v[i] = rand_comp();
			// Occasionally zero one quaternion to hit the zero-norm flag.
			if ($urandom_range(0, 30) == 0)
				for (int i = 0; i < 4; i++) v[4*(n%2) + i] = 16'h0000;
			send_item(pack_pair(v));
		end
	endtask

	// Long receiver hold-off while items keep coming, then a full drain.
	task automatic test_backpressure();
		hold_cycles = 150;
		test_random(100);
		wait_drained();
	endtask

	// Output side: random stalls, the long hold-off, and result checking.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (recv_idle) begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		quat_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected result p=%h zero_norm=%b", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = expected_products.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_axis_tdata[16*i +: 16] !== want.p[i]) begin
						$display("%0t: component %0d expected %h actual %h", $time, i,
							want.p[i], m_axis_tdata[16*i +: 16]);
						errors++;
					end
				if (m_axis_tuser !== want.zero) begin
					$display("%0t: zero_norm expected %b actual %b", $time,
						want.zero, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// Run-time limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_quaternion_multiply_normalize failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(1100);
		wait_drained();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		test_random(400);
		wait_drained();
		repeat (Latency) @(negedge clk);
		if (errors == 0 && expected_products.size() == 0) begin
			$display("tb_quaternion_multiply_normalize passed");
		end else begin
			$display("tb_quaternion_multiply_normalize failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/qmn_pkg.sv
design/qmn_product.sv
design/qmn_scale.sv
design/qmn_sqrt.sv
design/qmn_divide.sv
design/quaternion_multiply_normalize.sv
dv/tb_quaternion_multiply_normalize.sv
